// File: rtl/adamax_pkg.sv
// Shared constants and types for the AdaMax update engine.
// No dependencies; used by adamax_ram users and the top level by scoped names.
package adamax_pkg;

    // Data and gain formats
    localparam int DATA_WIDTH  = 32;               // signed Q16.16 gradient, moment, update
    localparam int NORM_WIDTH  = DATA_WIDTH - 1;   // unsigned infinity norm
    localparam int GAIN_WIDTH  = 16;               // unsigned Q0.16 gains
    localparam int FRAC_BITS   = 16;
    localparam int POWER_WIDTH = GAIN_WIDTH + 1;   // b1 power, holds one exactly
    localparam logic [POWER_WIDTH-1:0] ONE_Q16 = POWER_WIDTH'(1) << FRAC_BITS;

    // Element store
    localparam int INDEX_WIDTH = 12;
    localparam int ELEMENTS    = 4096;             // power of two: slot is the low index bits
    localparam int SLOT_WIDTH  = $clog2(ELEMENTS);
    localparam int MEM_WIDTH   = DATA_WIDTH + NORM_WIDTH;

    // Configuration register map
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_STEP_SIZE   = 2'd0,
        CFG_FIRST_DECAY = 2'd1,
        CFG_NORM_DECAY  = 2'd2,
        CFG_STABILIZER  = 2'd3
    } cfg_reg_t;

endpackage

// File: rtl/adamax_optimizer_update_top.sv
// AdaMax update engine: per-element moment/norm store, update pipeline and divider.
// Depends on adamax_pkg and adamax_ram.
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid, in_stall, element_index, gradient,     | request in
//          | last_in_pass                                     |
//  out     | out_valid, out_stall, result_index,              | request out
//          | weight_update, pass_done                         |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data        | write in
//
// One request per cycle sustained while in_stall is low; an accepted request passes a
// 5-stage front end (the first loaded at acceptance), the one-bit-per-stage divider
// (32 stages) and the output register, which raises out_valid.
// After reset a clearing pass writes zero to all 4096 store entries; in_stall stays high
// until it ends. Config writes are taken at any time. A stalled result parks in the
// output register, one more in a skid stage; in_stall rises only once the skid stage
// is full, and the whole pipeline holds with it.
module adamax_optimizer_update_top (
    input  logic                                       clk,
    input  logic                                       rst_n,
    // config write channel
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [adamax_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [adamax_pkg::CFG_DATA_WIDTH-1:0]      cfg_data,
    // input requests
    input  logic                                       in_valid,
    output logic                                       in_stall,
    input  logic [adamax_pkg::INDEX_WIDTH-1:0]         element_index,
    input  logic signed [adamax_pkg::DATA_WIDTH-1:0]   gradient,
    input  logic                                       last_in_pass,
    // result requests
    output logic                                       out_valid,
    input  logic                                       out_stall,
    output logic [adamax_pkg::INDEX_WIDTH-1:0]         result_index,
    output logic signed [adamax_pkg::DATA_WIDTH-1:0]   weight_update,
    output logic                                       pass_done
);

    localparam int DW      = adamax_pkg::DATA_WIDTH;
    localparam int NW      = adamax_pkg::NORM_WIDTH;
    localparam int GW      = adamax_pkg::GAIN_WIDTH;
    localparam int FB      = adamax_pkg::FRAC_BITS;
    localparam int PW      = adamax_pkg::POWER_WIDTH;
    localparam int IW      = adamax_pkg::INDEX_WIDTH;
    localparam int SW      = adamax_pkg::SLOT_WIDTH;
    localparam int MW      = adamax_pkg::MEM_WIDTH;
    localparam int PM_W    = GW + 1 + DW;      // b1 * m
    localparam int PG_W    = GW + 2 + DW;      // (1 - b1) * g
    localparam int SUM_W   = PG_W + 1;
    localparam int PU_W    = GW + NW;          // b2 * u
    localparam int PB_W    = PW + GW;          // power * b1
    localparam int NUMP_W  = GW + DW;          // alpha * |m|
    localparam int NUM_W   = NUMP_W + FB;
    localparam int DEN_W   = PW + DW;          // c * v
    localparam int TRIAL_W = DEN_W + DW;

    localparam logic [NW-1:0] NORM_MAX = {NW{1'b1}};
    localparam logic [DW-1:0] DATA_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] DATA_MIN = {1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [DW-1:0]    q;
        logic             ovf;
        logic             zero;
        logic             neg;
        logic [IW-1:0]    idx;
        logic             last;
    } div_t;

    // configuration registers
    logic [GW-1:0] step_size_reg, first_decay_reg, norm_decay_reg, stabilizer_reg;
    logic [PW-1:0] power_reg;

    // clearing pass
    logic          clr_active_reg;
    logic [SW-1:0] clr_cnt_reg;

    // flow control
    logic skid_valid_reg;
    logic adv;
    logic accept;

    // stage A: store read returns
    logic                 valid_a_reg;
    logic [IW-1:0]        idx_a_reg;
    logic [SW-1:0]        slot_a_reg;
    logic signed [DW-1:0] g_a_reg;
    logic                 last_a_reg;
    logic [MW-1:0]        ram_rd_data;

    // stage B: products
    logic                    valid_b_reg;
    logic [IW-1:0]           idx_b_reg;
    logic [SW-1:0]           slot_b_reg;
    logic                    last_b_reg;
    logic signed [PM_W-1:0]  pm_b_reg;
    logic signed [PG_W-1:0]  pg_b_reg;
    logic [PU_W-1:0]         pu_b_reg;
    logic [NW-1:0]           mag_b_reg;
    logic [PW-1:0]           bt_b_reg;

    // last store write, kept for forwarding
    logic                 w_valid_reg;
    logic [SW-1:0]        w_slot_reg;
    logic signed [DW-1:0] w_m_reg;
    logic [NW-1:0]        w_u_reg;

    // stage C: new state
    logic                 valid_c_reg;
    logic [IW-1:0]        idx_c_reg;
    logic                 last_c_reg;
    logic signed [DW-1:0] m_c_reg;
    logic [DW-1:0]        v_c_reg;
    logic [PW-1:0]        bt_c_reg;

    // stage D: numerator and divisor
    logic              valid_d_reg;
    logic [IW-1:0]     idx_d_reg;
    logic              last_d_reg;
    logic              neg_d_reg;
    logic              zero_d_reg;
    logic [NUMP_W-1:0] nump_d_reg;
    logic [DEN_W-1:0]  den_d_reg;

    // divider stages
    div_t div_reg       [0:DW];
    logic div_valid_reg [0:DW];

    // output and skid
    logic                 out_valid_reg;
    logic [IW-1:0]        out_idx_reg;
    logic [DW-1:0]        out_upd_reg;
    logic                 out_last_reg;
    logic [IW-1:0]        skid_idx_reg;
    logic [DW-1:0]        skid_upd_reg;
    logic                 skid_last_reg;

    // combinational values
    logic signed [DW-1:0]  m_old;
    logic [NW-1:0]         u_old;
    logic signed [GW:0]    b1_s;
    logic signed [GW+1:0]  ob1_s;
    logic [DW-1:0]         g_abs;
    logic [NW-1:0]         mag_a;
    logic [PB_W-1:0]       pb_a;
    logic [PW-1:0]         bt_a;
    logic signed [SUM_W-1:0] sum_b;
    logic signed [DW-1:0]  m_new_b;
    logic [NW-1:0]         decayed_b;
    logic [NW-1:0]         u_new_b;
    logic [DW-1:0]         v_b;
    logic [DW-1:0]         mm_c;
    logic [PW-1:0]         corr_c;
    logic [NUM_W-1:0]      num_d;
    logic                  ovf_d;
    logic                  ram_wr_en;
    logic [SW-1:0]         ram_wr_addr;
    logic [MW-1:0]         ram_wr_data;
    logic [DW-1:0]         upd_f;
    div_t                  fin;

    assign cfg_ready = 1'b1;
    assign adv       = !skid_valid_reg;
    assign in_stall  = clr_active_reg || skid_valid_reg;
    assign accept    = in_valid && !in_stall;

    // hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg   <= '0;
            first_decay_reg <= '0;
            norm_decay_reg  <= '0;
            stabilizer_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (adamax_pkg::cfg_reg_t'(cfg_index))
                adamax_pkg::CFG_STEP_SIZE:   step_size_reg   <= cfg_data;
                adamax_pkg::CFG_FIRST_DECAY: first_decay_reg <= cfg_data;
                adamax_pkg::CFG_NORM_DECAY:  norm_decay_reg  <= cfg_data;
                adamax_pkg::CFG_STABILIZER:  stabilizer_reg  <= cfg_data;
                default:                     step_size_reg   <= step_size_reg;
            endcase
        end
    end

    // sweep the store to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + SW'(1);
            if (clr_cnt_reg == SW'(adamax_pkg::ELEMENTS - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // store write port: clearing pass or stage B write-back
    always_comb
    begin
        ram_wr_en   = clr_active_reg || (adv && valid_b_reg);
        ram_wr_addr = clr_active_reg ? clr_cnt_reg : slot_b_reg;
        ram_wr_data = clr_active_reg ? '0 : {m_new_b, u_new_b};
    end

    adamax_ram #(
        .WIDTH(MW),
        .DEPTH(adamax_pkg::ELEMENTS)
    ) u_state_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (adv),
        .rd_addr(element_index[SW-1:0]),
        .rd_data(ram_rd_data)
    );

    // stage A: forward the freshest state, then multiply
    always_comb
    begin
        priority if (valid_b_reg && slot_b_reg == slot_a_reg)
        begin
            m_old = m_new_b;
            u_old = u_new_b;
        end
        else if (w_valid_reg && w_slot_reg == slot_a_reg)
        begin
            m_old = w_m_reg;
            u_old = w_u_reg;
        end
        else
        begin
            m_old = ram_rd_data[MW-1:NW];
            u_old = ram_rd_data[NW-1:0];
        end
        b1_s  = signed'({1'b0, first_decay_reg});
        ob1_s = signed'({1'b0, PW'(adamax_pkg::ONE_Q16 - PW'(first_decay_reg))});
        g_abs = g_a_reg[DW-1] ? (~g_a_reg + DW'(1)) : g_a_reg;
        mag_a = g_abs[DW-1] ? NORM_MAX : g_abs[NW-1:0];
        pb_a  = power_reg * first_decay_reg;
        bt_a  = pb_a[PB_W-1:FB];
    end

    // stage B: new moment and norm
    always_comb
    begin
        sum_b     = SUM_W'(pm_b_reg) + SUM_W'(pg_b_reg);
        m_new_b   = DW'(sum_b >>> FB);
        decayed_b = pu_b_reg[PU_W-1:FB];
        u_new_b   = (decayed_b > mag_b_reg) ? decayed_b : mag_b_reg;
        v_b       = {1'b0, u_new_b} + DW'(stabilizer_reg);
    end

    // stage C: magnitude and bias divisor
    always_comb
    begin
        mm_c   = m_c_reg[DW-1] ? (~m_c_reg + DW'(1)) : m_c_reg;
        corr_c = adamax_pkg::ONE_Q16 - bt_c_reg;
    end

    // stage D: scale numerator and flag a quotient beyond the data range
    always_comb
    begin
        num_d = {nump_d_reg, {FB{1'b0}}};
        ovf_d = TRIAL_W'(num_d) >= {den_d_reg, {DW{1'b0}}};
    end

    // advance control of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
            w_valid_reg <= 1'b0;
            power_reg   <= adamax_pkg::ONE_Q16;
        end
        else if (adv)
        begin
            valid_a_reg <= accept;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
            valid_d_reg <= valid_c_reg;
            w_valid_reg <= valid_b_reg;
            if (valid_a_reg && last_a_reg)
            begin
                power_reg <= bt_a;
            end
        end
    end

    // advance payload of the front stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            idx_a_reg  <= element_index;
            slot_a_reg <= element_index[SW-1:0];
            g_a_reg    <= gradient;
            last_a_reg <= last_in_pass;

            idx_b_reg  <= idx_a_reg;
            slot_b_reg <= slot_a_reg;
            last_b_reg <= last_a_reg;
            pm_b_reg   <= b1_s * m_old;
            pg_b_reg   <= ob1_s * g_a_reg;
            pu_b_reg   <= norm_decay_reg * u_old;
            mag_b_reg  <= mag_a;
            bt_b_reg   <= bt_a;

            w_slot_reg <= slot_b_reg;
            w_m_reg    <= m_new_b;
            w_u_reg    <= u_new_b;

            idx_c_reg  <= idx_b_reg;
            last_c_reg <= last_b_reg;
            m_c_reg    <= m_new_b;
            v_c_reg    <= v_b;
            bt_c_reg   <= bt_b_reg;

            idx_d_reg  <= idx_c_reg;
            last_d_reg <= last_c_reg;
            neg_d_reg  <= m_c_reg[DW-1];
            zero_d_reg <= (v_c_reg == '0);
            nump_d_reg <= step_size_reg * mm_c;
            den_d_reg  <= corr_c * v_c_reg;
        end
    end

    // load the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            div_valid_reg[0] <= valid_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_reg[0].rem  <= num_d;
            div_reg[0].den  <= den_d_reg;
            div_reg[0].q    <= '0;
            div_reg[0].ovf  <= ovf_d;
            div_reg[0].zero <= zero_d_reg;
            div_reg[0].neg  <= neg_d_reg;
            div_reg[0].idx  <= idx_d_reg;
            div_reg[0].last <= last_d_reg;
        end
    end

    // restoring divider, one quotient bit per stage, most significant first
    for (genvar k = 0; k < DW; k++)
    begin : g_div
        logic [TRIAL_W-1:0] trial;
        logic [TRIAL_W-1:0] rem_ext;
        div_t               stage_next;

        always_comb
        begin
            trial      = TRIAL_W'(div_reg[k].den) << (DW - 1 - k);
            rem_ext    = TRIAL_W'(div_reg[k].rem);
            stage_next = div_reg[k];
            if (rem_ext >= trial)
            begin
                stage_next.rem          = NUM_W'(rem_ext - trial);
                stage_next.q[DW - 1 - k] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_valid_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                div_valid_reg[k+1] <= div_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_reg[k+1] <= stage_next;
            end
        end
    end

    // sign and saturate the quotient
    always_comb
    begin
        fin = div_reg[DW];
        priority if (fin.zero)
        begin
            upd_f = '0;
        end
        else if (!fin.neg)
        begin
            upd_f = (fin.ovf || fin.q > DATA_MIN) ? DATA_MIN : (~fin.q + DW'(1));
        end
        else
        begin
            upd_f = (fin.ovf || fin.q > DATA_MAX) ? DATA_MAX : fin.q;
        end
    end

    // output register with a skid stage behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg  <= skid_valid_reg || div_valid_reg[DW];
            skid_valid_reg <= 1'b0;
        end
        else if (div_valid_reg[DW] && adv)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_idx_reg  <= skid_idx_reg;
                out_upd_reg  <= skid_upd_reg;
                out_last_reg <= skid_last_reg;
            end
            else
            begin
                out_idx_reg  <= fin.idx;
                out_upd_reg  <= upd_f;
                out_last_reg <= fin.last;
            end
        end
        else if (adv)
        begin
            skid_idx_reg  <= fin.idx;
            skid_upd_reg  <= upd_f;
            skid_last_reg <= fin.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_index  = out_idx_reg;
    assign weight_update = out_upd_reg;
    assign pass_done     = out_last_reg;

    // the skid stage only fills behind a held output
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full without a held output");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid stage filled while output was free");

    // the clearing pass owns the write port alone
    a_clear_alone: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !valid_a_reg && !valid_b_reg)
        else $error("pipeline active during clearing pass");

    // the running power of b1 never exceeds one
    a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
        power_reg <= adamax_pkg::ONE_Q16)
        else $error("decay power above one");

    // a pass end moves the power only with the pipeline
    a_power_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!adv) |-> $stable(power_reg))
        else $error("decay power changed during a hold");

endmodule

// File: rtl/adamax_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies; read returns old data on a same-address write.
module adamax_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // write the array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // register the read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: tb/adamax_optimizer_update_top_test.sv
// Self-checking testbench for the AdaMax update engine: random and directed gradient requests,
// a per-element moment/norm predictor and an in-order check of every result.
// Depends on adamax_pkg and the adamax_optimizer_update_top RTL.
module adamax_optimizer_update_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int INDEX_WIDTH     = adamax_pkg::INDEX_WIDTH;
    localparam int DATA_WIDTH      = adamax_pkg::DATA_WIDTH;
    localparam int NORM_WIDTH      = adamax_pkg::NORM_WIDTH;
    localparam int POWER_WIDTH     = adamax_pkg::POWER_WIDTH;
    localparam int ELEMENTS        = adamax_pkg::ELEMENTS;
    localparam int CFG_INDEX_WIDTH = adamax_pkg::CFG_INDEX_WIDTH;
    localparam int CFG_DATA_WIDTH  = adamax_pkg::CFG_DATA_WIDTH;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 60;

    typedef struct packed {
        logic [INDEX_WIDTH-1:0]        index;
        logic signed [DATA_WIDTH-1:0]  grad;
        logic                          last;
    } grad_req_t;

    typedef struct packed {
        logic [INDEX_WIDTH-1:0]        index;
        logic signed [DATA_WIDTH-1:0]  upd;
        logic                          done;
    } update_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [INDEX_WIDTH-1:0] element_index = '0;
    logic signed [DATA_WIDTH-1:0] gradient = '0;
    logic last_in_pass = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [INDEX_WIDTH-1:0] result_index;
    logic signed [DATA_WIDTH-1:0] weight_update;
    logic pass_done;

    adamax_optimizer_update_top dut (.*);

    always #5 clk = ~clk;

    // predictor copy of registers and stores
    logic [15:0] alpha_q, beta1_q, beta2_q, eps_q;
    logic signed [DATA_WIDTH-1:0] moment_mem [ELEMENTS];
    logic [NORM_WIDTH-1:0] norm_mem [ELEMENTS];
    logic [POWER_WIDTH-1:0] power_q;

    grad_req_t pending_reqs [$];
    update_t   expected_updates [$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_len = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_cnt = 0;
    int errors = 0;
    int cycles = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // work out the update for one accepted request and advance the stores
    function automatic update_t adamax_update(input grad_req_t r);
        update_t res;
        int slot;
        longint g, m_new, m_old;
        logic [63:0] mag, decayed, u_new, bt, corr, v, mm, num, den, q;
        slot = r.index % ELEMENTS;
        g = r.grad;
        m_old = moment_mem[slot];
        m_new = (longint'(beta1_q) * m_old + (65536 - longint'(beta1_q)) * g) >>> 16;
        mag = (g < 0) ? 64'(-g) : 64'(g);
        if (mag > 64'h7FFF_FFFF)
            mag = 64'h7FFF_FFFF;
        decayed = (64'(beta2_q) * 64'(norm_mem[slot])) >> 16;
        u_new = (decayed > mag) ? decayed : mag;
        bt = (64'(power_q) * 64'(beta1_q)) >> 16;
        corr = 64'd65536 - bt;
        v = u_new + 64'(eps_q);
        res.index = r.index;
        res.done = r.last;
        res.upd = '0;
        if (v != 0)
        begin
            mm = (m_new < 0) ? 64'(-m_new) : 64'(m_new);
            num = (64'(alpha_q) * mm) << 16;
            den = corr * v;
            q = num / den;
            if (m_new >= 0)
            begin
                if (q > 64'h8000_0000)
                    q = 64'h8000_0000;
                res.upd = DATA_WIDTH'(-longint'(q));
            end
            else
            begin
                if (q > 64'h7FFF_FFFF)
                    q = 64'h7FFF_FFFF;
                res.upd = DATA_WIDTH'(q);
            end
        end
        moment_mem[slot] = DATA_WIDTH'(m_new);
        norm_mem[slot] = NORM_WIDTH'(u_new);
        if (r.last)
            power_q = POWER_WIDTH'(bt);
        return res;
    endfunction

    initial
    begin
        alpha_q = '0; beta1_q = '0; beta2_q = '0; eps_q = '0;
        power_q = adamax_pkg::ONE_Q16;
        for (int i = 0; i < ELEMENTS; i++)
        begin
            moment_mem[i] = '0;
            norm_mem[i] = '0;
        end
    end

    // track register writes as the block takes them
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (adamax_pkg::cfg_reg_t'(cfg_index))
                adamax_pkg::CFG_STEP_SIZE:   alpha_q = cfg_data;
                adamax_pkg::CFG_FIRST_DECAY: beta1_q = cfg_data;
                adamax_pkg::CFG_NORM_DECAY:  beta2_q = cfg_data;
                adamax_pkg::CFG_STABILIZER:  eps_q = cfg_data;
                default: ;
            endcase
        end
    end

    // driver: predict on acceptance, hold while stalled, else offer the next request
    always @(posedge clk)
    begin
        grad_req_t r;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_updates.push_back(adamax_update({element_index, gradient, last_in_pass}));
            if (!(in_valid && in_stall))
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    r = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    element_index <= r.index;
                    gradient <= r.grad;
                    last_in_pass <= r.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_cnt <= hold_len;
        end
        else if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
    end

    // monitor: compare each taken result with the oldest expectation
    always @(posedge clk)
    begin
        update_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_updates.size() == 0)
                    report_mismatch("unexpected result, index", result_index, -1);
                else
                begin
                    e = expected_updates.pop_front();
                    if (result_index !== e.index)
                        report_mismatch("result_index", result_index, e.index);
                    if (weight_update !== e.upd)
                        report_mismatch("weight_update", weight_update, e.upd);
                    if (pass_done !== e.done)
                        report_mismatch("pass_done", pass_done, e.done);
                end
            end
            out_stall <= (hold_cnt > 1) || (hold_seq != hold_seen)
                         || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(input adamax_pkg::cfg_reg_t idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_gains(input logic [15:0] a, b1, b2, e);
        write_reg(adamax_pkg::CFG_STEP_SIZE, a);
        write_reg(adamax_pkg::CFG_FIRST_DECAY, b1);
        write_reg(adamax_pkg::CFG_NORM_DECAY, b2);
        write_reg(adamax_pkg::CFG_STABILIZER, e);
    endtask

    // wait until every request is sent and every result is back, then let the pipe settle
    task automatic drain();
        while (pending_reqs.size() > 0 || in_valid || expected_updates.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic grad_req_t random_req();
        grad_req_t r;
        r.index = ($urandom_range(9) == 0) ? INDEX_WIDTH'($urandom)
                                           : INDEX_WIDTH'($urandom_range(15));
        case ($urandom_range(4))
            0: r.grad = $urandom;
            1: r.grad = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            2: r.grad = 32'(int'($urandom_range(131072)) - 65536);
            default: r.grad = 32'(int'($urandom_range(33554432)) - 16777216);
        endcase
        r.last = ($urandom_range(7) == 0);
        return r;
    endfunction

    task automatic random_phase(input int n, input int idle, input int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (n) pending_reqs.push_back(random_req());
        drain();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: zero divisor, field extremes, pass ends
        set_gains(16'hFFFF, 16'd58982, 16'hFFFF, 16'd0);
        pending_reqs.push_back('{12'd0, 32'sd0, 1'b0});
        pending_reqs.push_back('{12'd4095, 32'sh7FFF_FFFF, 1'b0});
        pending_reqs.push_back('{12'd4095, 32'sh8000_0000, 1'b0});
        pending_reqs.push_back('{12'd1, 32'sh8000_0000, 1'b1});
        pending_reqs.push_back('{12'd1, 32'sd1, 1'b0});
        pending_reqs.push_back('{12'd2, -32'sd1, 1'b1});
        pending_reqs.push_back('{12'd2, 32'sd65536, 1'b0});
        pending_reqs.push_back('{12'd3, 32'sd0, 1'b1});
        pending_reqs.push_back('{12'd2048, 32'sh5555_5555, 1'b0});
        pending_reqs.push_back('{12'd2730, 32'shAAAA_AAAA, 1'b1});
        drain();
        set_gains(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        pending_reqs.push_back('{12'd0, 32'sd0, 1'b1});
        pending_reqs.push_back('{12'd5, 32'sh7FFF_FFFF, 1'b1});
        pending_reqs.push_back('{12'd5, -32'sd3, 1'b0});
        drain();
        set_gains(16'hFFFF, 16'hFFFF, 16'd32768, 16'd1);
        pending_reqs.push_back('{12'd6, 32'sh8000_0000, 1'b1});
        pending_reqs.push_back('{12'd6, 32'sd100, 1'b1});
        pending_reqs.push_back('{12'd7, 32'sd0, 1'b0});
        drain();

        // random phases across idling patterns and gain settings
        random_phase(250, 0, 0);
        set_gains(16'd6554, 16'd58982, 16'd65470, 16'd66);
        random_phase(250, 76, 0);
        random_phase(250, 0, 76);
        set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
        random_phase(200, 33, 33);
        set_gains(16'd1, 16'd0, 16'd0, 16'hFFFF);
        random_phase(150, 0, 0);

        // long receiver hold-off while the sender keeps offering
        set_gains(16'd40000, 16'd60000, 16'd50000, 16'd7);
        hold_len = 400;
        hold_seq++;
        random_phase(300, 0, 0);

        drain();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
